FILE: src/asfe_pkg.sv
// Shared types, constants and the saturation-pressure table of the sensor
// feature extractor. No dependencies; used by every module in src.
package asfe_pkg;

    localparam int TEMP_W   = 11;
    localparam int HUM_W    = 10;
    localparam int LUX_W    = 16;
    localparam int SOIL_W   = 10;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int VPD_W    = 16;
    localparam int WIN_W    = 3;
    localparam int MARGIN_W = 11;
    localparam int TMIN_W   = 11;
    localparam int PRESS_W  = 40;
    localparam int PROD_W   = 50;
    localparam int QUOT_W   = 28;
    localparam int RECIP_W  = 29;
    localparam int RECIP_SH = 40;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int ROM_DEPTH = 2048;

    localparam logic [LUX_W-1:0] LIGHT_ACTIVE_MIN_DEF = 16'd500;

    localparam logic [HUM_W-1:0]  HUM_FULL  = 10'd1000;
    localparam logic [PROD_W-1:0] HALF_DIV  = 50'd3276800000;
    localparam logic [QUOT_W:0]   SAT_LIM   = 29'd204800000;
    localparam logic [RECIP_W-1:0] RECIP_3125 = 29'd351843721;
    localparam logic [VPD_W-1:0]  VPD_MAX   = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DAWN      = 3'd0,
        REG_FORENOON  = 3'd1,
        REG_NOON      = 3'd2,
        REG_AFTERNOON = 3'd3,
        REG_EVENING   = 3'd4,
        REG_NIGHT     = 3'd5,
        REG_DARK_LUX  = 3'd6,
        REG_SOIL_TGT  = 3'd7
    } reg_idx_t;

    typedef enum logic [WIN_W-1:0] {
        WIN_NIGHT     = 3'd0,
        WIN_DAWN      = 3'd1,
        WIN_FORENOON  = 3'd2,
        WIN_NOON      = 3'd3,
        WIN_AFTERNOON = 3'd4,
        WIN_EVENING   = 3'd5
    } win_t;

    typedef struct packed {
        logic [HOUR_W-1:0] dawn;
        logic [HOUR_W-1:0] forenoon;
        logic [HOUR_W-1:0] noon;
        logic [HOUR_W-1:0] afternoon;
        logic [HOUR_W-1:0] evening;
        logic [HOUR_W-1:0] night;
        logic [LUX_W-1:0]  dark_lux;
        logic [SOIL_W-1:0] soil_target;
    } cfg_t;

    typedef struct packed {
        win_t                        window;
        logic                        active;
        logic signed [MARGIN_W-1:0]  margin;
    } feat_t;

    typedef logic [PRESS_W-1:0] press_rom_t [ROM_DEPTH];

    function automatic logic [63:0] mul_q32(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ah, al, bh, bl, lo;
        ah = {32'd0, a[63:32]};
        al = {32'd0, a[31:0]};
        bh = {32'd0, b[63:32]};
        bl = {32'd0, b[31:0]};
        lo = al * bl;
        return ((ah * bh) << 32) + ah * bl + al * bh + (lo >> 32);
    endfunction

    // restoring long division, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], n[i]};
            if (r >= {1'b0, d}) begin
                r = r - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] exp_mag(input logic [63:0] a);
        logic [63:0] z, sum, term;
        z = a >> 4;
        sum = 64'd1 << 32;
        term = 64'd1 << 32;
        for (int n = 1; n <= 18; n++) begin
            term = udiv64(mul_q32(term, z), 64'(n));
            sum = sum + term;
        end
        for (int i = 0; i < 4; i++) begin
            sum = mul_q32(sum, sum);
        end
        return sum;
    endfunction

    // (61078 * es_q32) >> 16 for one raw temperature code
    function automatic logic [PRESS_W-1:0] press_entry(input logic [TEMP_W-1:0] code);
        logic signed [63:0] t;
        logic [63:0] mag, den, a, e, q, rem, p;
        t = 64'(signed'(code));
        mag = code[TEMP_W-1] ? 64'(-t) : 64'(t);
        den = 64'(t + 64'sd2373) * 64'd100;
        a = udiv64((64'd1727 * mag) << 32, den);
        e = exp_mag(a);
        if (code[TEMP_W-1]) begin
            q = udiv64(64'd1 << 63, e);
            rem = (64'd1 << 63) - q * e;
            e = (q << 1) + udiv64((rem << 1) + (e >> 1), e);
        end
        p = (64'd61078 * e) >> 16;
        return p[PRESS_W-1:0];
    endfunction

    function automatic press_rom_t build_press_rom();
        press_rom_t rom;
        for (int i = 0; i < ROM_DEPTH; i++) begin
            rom[i] = press_entry(TEMP_W'(i));
        end
        return rom;
    endfunction

    localparam press_rom_t PRESS_ROM = build_press_rom();

endpackage

FILE: src/asfe_time_feat.sv
// Time-window, light-activity and soil-margin features of one snapshot.
// Depends on asfe_pkg.
module asfe_time_feat #(
    parameter logic [asfe_pkg::LUX_W-1:0] LIGHT_ACTIVE_MIN = asfe_pkg::LIGHT_ACTIVE_MIN_DEF
) (
    input  asfe_pkg::cfg_t                 cfg,
    input  logic [asfe_pkg::HOUR_W-1:0]    hour_of_day,
    input  logic [asfe_pkg::MIN_W-1:0]     minute_of_hour,
    input  logic [asfe_pkg::LUX_W-1:0]     light_level,
    input  logic [asfe_pkg::SOIL_W-1:0]    soil_moisture,
    output asfe_pkg::feat_t                feat
);

    localparam int TW = asfe_pkg::TMIN_W;

    function automatic logic [TW-1:0] to_min(input logic [asfe_pkg::HOUR_W-1:0] h);
        return TW'(h) * TW'(60);
    endfunction

    logic [TW-1:0] tmin;

    assign tmin = to_min(hour_of_day) + TW'(minute_of_hour);

    always_comb begin
        if (tmin >= to_min(cfg.night) || tmin < to_min(cfg.dawn)) begin
            feat.window = asfe_pkg::WIN_NIGHT;
        end else if (tmin < to_min(cfg.forenoon)) begin
            feat.window = asfe_pkg::WIN_DAWN;
        end else if (tmin < to_min(cfg.noon)) begin
            feat.window = asfe_pkg::WIN_FORENOON;
        end else if (tmin < to_min(cfg.afternoon)) begin
            feat.window = asfe_pkg::WIN_NOON;
        end else if (tmin < to_min(cfg.evening)) begin
            feat.window = asfe_pkg::WIN_AFTERNOON;
        end else begin
            feat.window = asfe_pkg::WIN_EVENING;
        end

        // bright wins over the dark limit
        if (feat.window == asfe_pkg::WIN_NIGHT) begin
            feat.active = 1'b0;
        end else if (light_level > LIGHT_ACTIVE_MIN) begin
            feat.active = 1'b1;
        end else if (light_level < cfg.dark_lux) begin
            feat.active = 1'b0;
        end else begin
            feat.active = 1'b1;
        end

        feat.margin = signed'(asfe_pkg::MARGIN_W'(soil_moisture)
                              - asfe_pkg::MARGIN_W'(cfg.soil_target));
    end

endmodule

FILE: src/agri_sensor_feature_extractor.sv
// Top level of the sensor feature extractor: config registers, four-stage
// pipeline with the saturation-pressure table. Depends on asfe_pkg, asfe_time_feat.
//
//  channel  | direction | beat contents
//  s_       | in        | one sensor snapshot
//  m_       | out       | one feature item per snapshot
//  cfg_     | in        | register write, no handshake
//
// One beat is taken every cycle while m_tready does not stall; the table
// read is in stage 1 and the two multipliers are in stages 2 and 3.
// Reset clears the valid bits and loads the register defaults.
// A stall at m_tready holds each stage and fills the empty ones behind it.
module agri_sensor_feature_extractor #(
    parameter logic [asfe_pkg::LUX_W-1:0] LIGHT_ACTIVE_MIN = asfe_pkg::LIGHT_ACTIVE_MIN_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // air_temp[10:0] air_humidity[20:11] light_level[36:21] soil_moisture[46:37]
    // hour_of_day[51:47] minute_of_hour[57:52], zero fill above
    input  logic [asfe_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // vpd_pa[15:0] day_window[18:16] light_active[19] soil_margin[30:20], zero fill
    output logic [asfe_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                              cfg_wr_en,
    input  logic [asfe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [asfe_pkg::CFG_DAT_W-1:0]    cfg_wdata
);

    localparam int PW = asfe_pkg::PRESS_W;
    localparam int RW = asfe_pkg::PROD_W;
    localparam int QW = asfe_pkg::QUOT_W;
    localparam int MW = QW + asfe_pkg::RECIP_W;

    asfe_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dawn        <= 5'd5;
            cfg_reg.forenoon    <= 5'd8;
            cfg_reg.noon        <= 5'd11;
            cfg_reg.afternoon   <= 5'd14;
            cfg_reg.evening     <= 5'd17;
            cfg_reg.night       <= 5'd20;
            cfg_reg.dark_lux    <= 16'd50;
            cfg_reg.soil_target <= 10'd600;
        end else if (cfg_wr_en) begin
            case (asfe_pkg::reg_idx_t'(cfg_index))
                asfe_pkg::REG_DAWN:      cfg_reg.dawn        <= cfg_wdata[4:0];
                asfe_pkg::REG_FORENOON:  cfg_reg.forenoon    <= cfg_wdata[4:0];
                asfe_pkg::REG_NOON:      cfg_reg.noon        <= cfg_wdata[4:0];
                asfe_pkg::REG_AFTERNOON: cfg_reg.afternoon   <= cfg_wdata[4:0];
                asfe_pkg::REG_EVENING:   cfg_reg.evening     <= cfg_wdata[4:0];
                asfe_pkg::REG_NIGHT:     cfg_reg.night       <= cfg_wdata[4:0];
                asfe_pkg::REG_DARK_LUX:  cfg_reg.dark_lux    <= cfg_wdata;
                asfe_pkg::REG_SOIL_TGT:  cfg_reg.soil_target <= cfg_wdata[9:0];
                default: ;
            endcase
        end
    end

    asfe_pkg::feat_t feat_in;

    asfe_time_feat #(
        .LIGHT_ACTIVE_MIN(LIGHT_ACTIVE_MIN)
    ) u_time_feat (
        .cfg            (cfg_reg),
        .hour_of_day    (s_tdata[51:47]),
        .minute_of_hour (s_tdata[57:52]),
        .light_level    (s_tdata[36:21]),
        .soil_moisture  (s_tdata[46:37]),
        .feat           (feat_in)
    );

    // valid bits and stage enables
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4 = !v4_reg || m_tready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign s_tready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // stage 1: table read
    logic [PW-1:0]                press1_reg;
    logic [asfe_pkg::HUM_W-1:0]   hum1_reg;
    asfe_pkg::feat_t              feat1_reg, feat2_reg, feat3_reg, feat4_reg;

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            press1_reg <= asfe_pkg::PRESS_ROM[s_tdata[10:0]];
            hum1_reg   <= s_tdata[20:11];
            feat1_reg  <= feat_in;
        end
    end

    // stage 2: scale by the dry fraction
    logic [RW-1:0] prod2_reg;
    logic          zero2_reg, zero3_reg;

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            prod2_reg <= RW'(press1_reg) * RW'(asfe_pkg::HUM_FULL - hum1_reg);
            zero2_reg <= hum1_reg >= asfe_pkg::HUM_FULL;
            feat2_reg <= feat1_reg;
        end
    end

    // stage 3: round, drop 2^21, multiply by the reciprocal of 3125
    logic [RW-1:0] round3;
    logic [QW:0]   quot3;
    logic [MW-1:0] recip3_reg;
    logic          sat3_reg;

    assign round3 = prod2_reg + asfe_pkg::HALF_DIV;
    assign quot3  = round3[RW-1:21];

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            recip3_reg <= MW'(quot3[QW-1:0]) * MW'(asfe_pkg::RECIP_3125);
            sat3_reg   <= quot3 >= asfe_pkg::SAT_LIM;
            zero3_reg  <= zero2_reg;
            feat3_reg  <= feat2_reg;
        end
    end

    // stage 4: output register
    logic [asfe_pkg::VPD_W-1:0] vpd4_reg;

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            if (zero3_reg) begin
                vpd4_reg <= '0;
            end else if (sat3_reg) begin
                vpd4_reg <= asfe_pkg::VPD_MAX;
            end else begin
                vpd4_reg <= recip3_reg[asfe_pkg::RECIP_SH +: asfe_pkg::VPD_W];
            end
            feat4_reg <= feat3_reg;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {1'b0, feat4_reg.margin, feat4_reg.active, feat4_reg.window, vpd4_reg};

`ifndef SYNTHESIS
    a_night_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && feat4_reg.window == asfe_pkg::WIN_NIGHT) |-> !feat4_reg.active)
        else $error("active light flagged at night");

    a_dry_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && $past(rdy4) && $past(zero3_reg) && $past(v3_reg)) |-> vpd4_reg == '0)
        else $error("saturated humidity did not give zero deficit");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && !rdy3) |=> ($stable(recip3_reg) && v3_reg))
        else $error("stage 3 lost its item under stall");

    a_fill_behind: assert property (@(posedge aclk) disable iff (!aresetn)
        (!v2_reg) |-> rdy1)
        else $error("input blocked with a free stage ahead");
`endif

endmodule
